// ===== src/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the mapper RTL. They sample on clk and are
// disabled while arst_n is low.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCM_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define FCM_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== src/fcm_pkg.sv =====
// ============================================================================
// fcm_pkg
// Types, widths and constants of the fisheye coordinate mapper.
// ============================================================================
package fcm_pkg;

	localparam int COORD_W   = 16;
	localparam int LENS_W    = COORD_W - 1;
	localparam int GUARD_W   = 16;
	localparam int XY_W      = COORD_W + GUARD_W + 3;
	localparam int ANG_W     = 32;
	localparam int MAX_STEPS = 32;
	localparam int QUO_W     = COORD_W + 1;
	localparam int REM_W     = COORD_W + 2;
	localparam int PROD_W    = 2 * COORD_W;

	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_LENS = REG_IDX_W'(0);

	localparam logic [31:0]       TWO_OVER_PI_Q32 = 32'd2734261102;
	localparam logic [LENS_W-1:0] LENS_RESET      = LENS_W'(16384);

	typedef logic signed [ANG_W-1:0] ang_t;

	// round(atan(2^-i) * 2^30)
	localparam ang_t ATAN_Q30 [MAX_STEPS] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] u_coord;
		logic signed [COORD_W-1:0] v_coord;
	} coord_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] mapped_u;
		logic signed [COORD_W-1:0] mapped_v;
	} mapped_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
		logic [COORD_W-1:0]        r;
	} root_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
		logic [COORD_W-1:0]        r;
		ang_t                      z;
	} angle_t;

	typedef struct packed {
		logic [PROD_W-1:0] num_u;
		logic [PROD_W-1:0] num_v;
		logic [QUO_W-1:0]  den;
		logic              neg_u;
		logic              neg_v;
		logic              zero;
	} frac_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo_u;
		logic [QUO_W-1:0] quo_v;
		logic             neg_u;
		logic             neg_v;
		logic             zero;
	} quot_t;

	function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] c);
		return c[COORD_W-1] ? COORD_W'(-c) : COORD_W'(c);
	endfunction

endpackage

// ===== src/fcm_sqrt_pipe.sv =====
// ============================================================================
// fcm_sqrt_pipe
// Squared radius and pipelined integer square root, one root bit per stage.
// ============================================================================
`include "assert_macros.svh"

module fcm_sqrt_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  fcm_pkg::coord_beat_t in_beat,
	output logic                out_vld,
	output fcm_pkg::root_t      out_root
);

	localparam int W  = fcm_pkg::COORD_W;
	localparam int RW = fcm_pkg::REM_W;

	logic                vld_s1, vld_s2;
	logic [W-1:0]        au_s1, av_s1;
	logic signed [W-1:0] u_s1, v_s1, u_s2, v_s2;
	logic [2*W-1:0]      usq_s2, vsq_s2;

	logic [W:0]          vld_s;
	logic [2*W-1:0]      rad_s  [W+1];
	logic [RW-1:0]       rem_s  [W+1];
	logic [W-1:0]        root_s [W+1];
	logic signed [W-1:0] u_s    [W+1];
	logic signed [W-1:0] v_s    [W+1];
	logic [RW-1:0]       root_x2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s  <= {vld_s[W-1:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			au_s1     <= fcm_pkg::mag(in_beat.u_coord);
			av_s1     <= fcm_pkg::mag(in_beat.v_coord);
			u_s1      <= in_beat.u_coord;
			v_s1      <= in_beat.v_coord;
			usq_s2    <= au_s1 * au_s1;
			vsq_s2    <= av_s1 * av_s1;
			u_s2      <= u_s1;
			v_s2      <= v_s1;
			rad_s[0]  <= usq_s2 + vsq_s2;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			u_s[0]    <= u_s2;
			v_s[0]    <= v_s2;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_root
		logic [RW-1:0] rem_sh, trial;

		always_comb begin
			rem_sh = {rem_s[k][W-1:0], rad_s[k][2*W-1 -: 2]};
			trial  = {root_s[k], 2'b01};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_s[k] << 2;
				u_s[k+1]   <= u_s[k];
				v_s[k+1]   <= v_s[k];
				if (rem_sh >= trial) begin
					rem_s[k+1]  <= rem_sh - trial;
					root_s[k+1] <= {root_s[k][W-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rem_sh;
					root_s[k+1] <= {root_s[k][W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[W];
	assign out_root = '{u: u_s[W], v: v_s[W], r: root_s[W]};
	assign root_x2  = {1'b0, root_s[W], 1'b0};

	`FCM_ASSERT_IMP(a_root_rem, vld_s[W], rem_s[W] <= root_x2, "sqrt remainder above 2*root")

endmodule

// ===== src/fcm_cordic_pipe.sv =====
// ============================================================================
// fcm_cordic_pipe
// Vectoring CORDIC, one micro-rotation per stage: angle of (R, r).
// ============================================================================
module fcm_cordic_pipe #(
	parameter int STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  fcm_pkg::root_t              in_root,
	input  logic [fcm_pkg::LENS_W-1:0]  big_r,
	output logic                        out_vld,
	output fcm_pkg::angle_t             out_ang
);

	localparam int N  = (STEPS > fcm_pkg::MAX_STEPS) ? fcm_pkg::MAX_STEPS : STEPS;
	localparam int XW = fcm_pkg::XY_W;
	localparam int G  = fcm_pkg::GUARD_W;

	logic [N:0]           vld_s;
	logic signed [XW-1:0] x_s  [N+1];
	logic signed [XW-1:0] y_s  [N+1];
	fcm_pkg::ang_t        z_s  [N+1];
	fcm_pkg::root_t       rt_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= XW'({big_r, {G{1'b0}}});
			y_s[0]  <= XW'({in_root.r, {G{1'b0}}});
			z_s[0]  <= '0;
			rt_s[0] <= in_root;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[i+1] <= rt_s[i];
				if (!y_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + fcm_pkg::ATAN_Q30[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - fcm_pkg::ATAN_Q30[i];
				end
			end
		end
	end

	assign out_vld = vld_s[N];
	assign out_ang = '{u: rt_s[N].u, v: rt_s[N].v, r: rt_s[N].r, z: z_s[N]};

endmodule

// ===== src/fcm_scale_pipe.sv =====
// ============================================================================
// fcm_scale_pipe
// Mapped length m = R*phi, then the numerators 2*|c|*m + r and divisor 2*r.
// ============================================================================
module fcm_scale_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  fcm_pkg::angle_t             in_ang,
	input  logic [fcm_pkg::LENS_W-1:0]  big_r,
	output logic                        out_vld,
	output fcm_pkg::frac_t              out_frac
);

	localparam int W     = fcm_pkg::COORD_W;
	localparam int ZW    = fcm_pkg::ANG_W - 1;
	localparam int MP_W  = fcm_pkg::LENS_W + ZW;
	localparam int MQ_W  = MP_W + 1 - 30;
	localparam int PW    = fcm_pkg::PROD_W;
	localparam logic [MP_W:0]   M_RND = (MP_W + 1)'(1) << 29;
	localparam logic [MQ_W-1:0] M_CAP = MQ_W'(1) << (W - 1);

	logic [5:1]         vld_s;
	logic [ZW-1:0]      zc_s1;
	logic [MP_W-1:0]    mp_s2;
	logic [W-1:0]       m_s3;
	logic [PW-1:0]      pu_s4, pv_s4;
	fcm_pkg::frac_t     frac_s5;

	logic [W-1:0]       au_s1, au_s2, au_s3;
	logic [W-1:0]       av_s1, av_s2, av_s3;
	logic [W-1:0]       r_s1, r_s2, r_s3, r_s4;
	logic [4:1]         neg_u_s, neg_v_s, zero_s;

	logic [MP_W:0]      m_rnd;
	logic [MQ_W-1:0]    m_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:1], in_vld};
		end
	end

	always_comb begin
		m_rnd  = {1'b0, mp_s2} + M_RND;
		m_wide = m_rnd[MP_W:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s1      <= in_ang.z[fcm_pkg::ANG_W-1] ? '0 : in_ang.z[ZW-1:0];
			au_s1      <= fcm_pkg::mag(in_ang.u);
			av_s1      <= fcm_pkg::mag(in_ang.v);
			r_s1       <= in_ang.r;
			neg_u_s[1] <= in_ang.u[W-1];
			neg_v_s[1] <= in_ang.v[W-1];
			zero_s[1]  <= (in_ang.r == '0) || (big_r == '0);

			mp_s2 <= big_r * zc_s1;
			au_s2 <= au_s1;
			av_s2 <= av_s1;
			r_s2  <= r_s1;

			m_s3  <= (m_wide > M_CAP) ? M_CAP[W-1:0] : m_wide[W-1:0];
			au_s3 <= au_s2;
			av_s3 <= av_s2;
			r_s3  <= r_s2;

			pu_s4 <= au_s3 * m_s3;
			pv_s4 <= av_s3 * m_s3;
			r_s4  <= r_s3;

			neg_u_s[4:2] <= neg_u_s[3:1];
			neg_v_s[4:2] <= neg_v_s[3:1];
			zero_s[4:2]  <= zero_s[3:1];

			frac_s5.num_u <= {pu_s4[PW-2:0], 1'b0} + PW'(r_s4);
			frac_s5.num_v <= {pv_s4[PW-2:0], 1'b0} + PW'(r_s4);
			frac_s5.den   <= {r_s4, 1'b0};
			frac_s5.neg_u <= neg_u_s[4];
			frac_s5.neg_v <= neg_v_s[4];
			frac_s5.zero  <= zero_s[4];
		end
	end

	assign out_vld  = vld_s[5];
	assign out_frac = frac_s5;

endmodule

// ===== src/fcm_div_pipe.sv =====
// ============================================================================
// fcm_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ============================================================================
`include "assert_macros.svh"

module fcm_div_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  fcm_pkg::frac_t in_frac,
	output logic           out_vld,
	output fcm_pkg::quot_t out_quo
);

	localparam int QW = fcm_pkg::QUO_W;
	localparam int PW = fcm_pkg::REM_W;
	localparam int NW = fcm_pkg::PROD_W;

	logic [QW:0]    vld_s;
	logic [PW-1:0]  pu_s  [QW+1];
	logic [PW-1:0]  pv_s  [QW+1];
	logic [QW-1:0]  nu_s  [QW+1];
	logic [QW-1:0]  nv_s  [QW+1];
	logic [QW-1:0]  qu_s  [QW+1];
	logic [QW-1:0]  qv_s  [QW+1];
	logic [QW-1:0]  den_s [QW+1];
	logic [QW:0]    neg_u_s, neg_v_s, zero_s;
	logic [PW-1:0]  den_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-1:0], in_vld};
		end
	end

	// numerator / 2^QW is below the divisor, so it seeds the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			pu_s[0]    <= PW'(in_frac.num_u[NW-1:QW]);
			pv_s[0]    <= PW'(in_frac.num_v[NW-1:QW]);
			nu_s[0]    <= in_frac.num_u[QW-1:0];
			nv_s[0]    <= in_frac.num_v[QW-1:0];
			qu_s[0]    <= '0;
			qv_s[0]    <= '0;
			den_s[0]   <= in_frac.den;
			neg_u_s[0] <= in_frac.neg_u;
			neg_v_s[0] <= in_frac.neg_v;
			zero_s[0]  <= in_frac.zero;
			neg_u_s[QW:1] <= neg_u_s[QW-1:0];
			neg_v_s[QW:1] <= neg_v_s[QW-1:0];
			zero_s[QW:1]  <= zero_s[QW-1:0];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [PW-1:0] tu, tv, dx;

		always_comb begin
			tu = {pu_s[k][PW-2:0], nu_s[k][QW-1]};
			tv = {pv_s[k][PW-2:0], nv_s[k][QW-1]};
			dx = PW'(den_s[k]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nu_s[k+1]  <= nu_s[k] << 1;
				nv_s[k+1]  <= nv_s[k] << 1;
				den_s[k+1] <= den_s[k];
				if (tu >= dx) begin
					pu_s[k+1] <= tu - dx;
					qu_s[k+1] <= {qu_s[k][QW-2:0], 1'b1};
				end else begin
					pu_s[k+1] <= tu;
					qu_s[k+1] <= {qu_s[k][QW-2:0], 1'b0};
				end
				if (tv >= dx) begin
					pv_s[k+1] <= tv - dx;
					qv_s[k+1] <= {qv_s[k][QW-2:0], 1'b1};
				end else begin
					pv_s[k+1] <= tv;
					qv_s[k+1] <= {qv_s[k][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign out_quo  = '{quo_u: qu_s[QW], quo_v: qv_s[QW], neg_u: neg_u_s[QW],
		neg_v: neg_v_s[QW], zero: zero_s[QW]};
	assign den_last = PW'(den_s[QW]);

	`FCM_ASSERT_IMP(a_rem_u_below_den, vld_s[QW] && !zero_s[QW], pu_s[QW] < den_last, "u remainder not below divisor")

endmodule

// ===== src/fisheye_coordinate_mapper.sv =====
// ============================================================================
// fisheye_coordinate_mapper
// Arctangent fisheye remap of a signed Q2.14 coordinate pair: the direction is
// kept and the length r becomes R*atan(r/R), R = lens_radius*2/pi.
//
//   channel  dir  handshake                      beat
//   coord    in   coord_valid / coord_ready      coord_beat_t  (u_coord, v_coord)
//   mapped   out  mapped_valid / mapped_ready    mapped_beat_t (mapped_u, mapped_v)
//   apb      in   psel, penable, pwrite, pready  lens_radius at byte address 0
//
// One beat per clock while the pipeline is not stalled (see below). A beat passes
// the squaring, root, CORDIC, scale and divider stages in turn, then the output register.
// Reset sets lens_radius to 1.0 and clears all stage valid bits.
// A result held at the output stalls the pipeline only when the last stage is
// also full; otherwise new beats keep entering.
// ============================================================================
`include "assert_macros.svh"

module fisheye_coordinate_mapper #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fcm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,

	input  logic                         coord_valid,
	output logic                         coord_ready,
	input  fcm_pkg::coord_beat_t         coord,

	output logic                         mapped_valid,
	input  logic                         mapped_ready,
	output fcm_pkg::mapped_beat_t        mapped
);

	localparam int W    = fcm_pkg::COORD_W;
	localparam int QW   = fcm_pkg::QUO_W;
	localparam int LW   = fcm_pkg::LENS_W;
	localparam int BR_W = LW + 32;
	localparam logic [QW-1:0] HALF    = QW'(1) << (W - 1);
	localparam logic [QW-1:0] HALF_M1 = HALF - QW'(1);

	logic [LW-1:0]          lens_q, big_r_q;
	logic [BR_W-1:0]        br_sum;
	logic                   cfg_wr;

	logic                   pipe_en, out_load;
	logic                   sqrt_vld, cor_vld, scl_vld, div_vld;
	fcm_pkg::root_t         sqrt_root;
	fcm_pkg::angle_t        cor_ang;
	fcm_pkg::frac_t         scl_frac;
	fcm_pkg::quot_t         div_quo;

	logic                   mapped_valid_q;
	fcm_pkg::mapped_beat_t  mapped_q;
	fcm_pkg::mapped_beat_t  mapped_d;

	function automatic logic signed [W-1:0] sat_sign(input logic [QW-1:0] q, input logic neg);
		logic [QW-1:0] lim;
		logic [QW-1:0] qc;
		lim = neg ? HALF : HALF_M1;
		qc  = (q > lim) ? lim : q;
		return neg ? W'(-qc) : W'(qc);
	endfunction

	// config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_q <= fcm_pkg::LENS_RESET;
		end else if (cfg_wr && (paddr[fcm_pkg::ADDR_W-1:2] == fcm_pkg::REG_LENS)) begin
			lens_q <= pwdata[LW-1:0];
		end
	end

	always_comb begin
		unique case (paddr[fcm_pkg::ADDR_W-1:2])
			fcm_pkg::REG_LENS: prdata = 32'(lens_q);
			default:           prdata = '0;
		endcase
	end

	// R = round(lens * 2/pi)
	assign br_sum = BR_W'(lens_q) * BR_W'(fcm_pkg::TWO_OVER_PI_Q32) + (BR_W'(1) << 31);

	always_ff @(posedge clk) begin
		big_r_q <= br_sum[BR_W-1:32];
	end

	// pipeline
	assign pipe_en     = !div_vld || !mapped_valid_q || mapped_ready;
	assign coord_ready = pipe_en;
	assign out_load    = pipe_en && div_vld;

	fcm_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_vld   (coord_valid),
		.in_beat  (coord),
		.out_vld  (sqrt_vld),
		.out_root (sqrt_root)
	);

	fcm_cordic_pipe #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.in_vld  (sqrt_vld),
		.in_root (sqrt_root),
		.big_r   (big_r_q),
		.out_vld (cor_vld),
		.out_ang (cor_ang)
	);

	fcm_scale_pipe u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_vld   (cor_vld),
		.in_ang   (cor_ang),
		.big_r    (big_r_q),
		.out_vld  (scl_vld),
		.out_frac (scl_frac)
	);

	fcm_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.in_vld  (scl_vld),
		.in_frac (scl_frac),
		.out_vld (div_vld),
		.out_quo (div_quo)
	);

	// output stage
	always_comb begin
		if (div_quo.zero) begin
			mapped_d = '0;
		end else begin
			mapped_d.mapped_u = sat_sign(div_quo.quo_u, div_quo.neg_u);
			mapped_d.mapped_v = sat_sign(div_quo.quo_v, div_quo.neg_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_valid_q <= 1'b0;
		end else if (out_load) begin
			mapped_valid_q <= 1'b1;
		end else if (mapped_ready) begin
			mapped_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mapped_q <= mapped_d;
		end
	end

	assign mapped_valid = mapped_valid_q;
	assign mapped       = mapped_q;

	`FCM_ASSERT_NXT(a_zero_result, out_load && div_quo.zero, mapped_q == '0, "zero case not cleared")
	`FCM_ASSERT_NXT(a_hold_on_stall, div_vld && !pipe_en, div_vld && mapped_valid_q, "stalled beat lost")

endmodule

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for fisheye_coordinate_mapper. A directed table of
// coordinate beats, then randomized phases at several lens radii. Each
// accepted coordinate beat is run through a bit-exact fixed-point model
// (integer root, CORDIC arctangent, rounded rescale) unless its table row
// gives the expected beat, and mapped beats are checked in order. Both
// sides idle at random, with one long output stall and one drain pause.
// ============================================================================
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     STEPS        = 16;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     CYCLE_LIMIT  = 300000;
	localparam int     PHASE_ITEMS  = 215;
	localparam int     NUM_PHASES   = 6;
	localparam int     IDLE_PCT     = 27;
	localparam longint TWO_OVER_PI  = 64'd2734261102;
	localparam logic [fcm_pkg::REG_IDX_W-1:0] REG_UNUSED = fcm_pkg::REG_IDX_W'(1);

	localparam longint ARCTAN_Q30 [32] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
	};

	typedef struct {
		logic [31:0]        lens_word;
		logic signed [15:0] u;
		logic signed [15:0] v;
		bit                 typed;
		logic signed [15:0] eu;
		logic signed [15:0] ev;
	} coord_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [fcm_pkg::ADDR_W-1:0]    paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          coord_valid;
	logic                          coord_ready;
	fcm_pkg::coord_beat_t          coord;
	logic                          mapped_valid;
	logic                          mapped_ready;
	fcm_pkg::mapped_beat_t         mapped;

	logic [fcm_pkg::LENS_W-1:0]    lens_shadow;
	fcm_pkg::mapped_beat_t         pending_maps [$];
	fcm_pkg::mapped_beat_t         oldest_map;
	bit                            beat_typed;
	fcm_pkg::mapped_beat_t         beat_typed_val;
	bit                            calm;
	bit                            hold_req;
	int                            errors;
	int                            cycle_count;

	coord_row_t directed [] = '{
		'{32'h0000_4000,      0,      0, 1, 0, 0},
		'{32'h0000_4000,  32767,  32767, 0, 0, 0},
		'{32'h0000_4000, -32768, -32768, 0, 0, 0},
		'{32'h0000_4000, -32768,  32767, 0, 0, 0},
		'{32'h0000_4000,  32767, -32768, 0, 0, 0},
		'{32'h0000_4000,      1,      0, 0, 0, 0},
		'{32'h0000_4000,      0,     -1, 0, 0, 0},
		'{32'h0000_4000, -32768,      0, 0, 0, 0},
		'{32'h0000_4000,      0,  32767, 0, 0, 0},
		'{32'h0000_4000,  16384,      0, 0, 0, 0},
		'{32'h0000_4000,     -1,     -1, 0, 0, 0},
		'{32'h0000_4000,  12345, -23456, 0, 0, 0},
		'{32'hFFFF_7FFF,  32767,  32767, 0, 0, 0},
		'{32'hFFFF_7FFF, -32768, -32768, 0, 0, 0},
		'{32'hFFFF_7FFF,      1,      1, 0, 0, 0},
		'{32'hFFFF_7FFF,      0,      1, 0, 0, 0},
		'{32'hFFFF_7FFF,      0,      0, 1, 0, 0},
		'{32'h0001_0000,  16384, -16384, 1, 0, 0},
		'{32'h0001_0000, -32768,  32767, 1, 0, 0},
		'{32'h0000_0001,  32767,      0, 0, 0, 0},
		'{32'h0000_0001, -32768,     -1, 0, 0, 0},
		'{32'h0000_0002,     -7,      3, 0, 0, 0},
		'{32'hFFFF_4002,  -9000,  30000, 0, 0, 0}
	};

	fisheye_coordinate_mapper #(.CORDIC_STEPS(STEPS)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.coord_valid  (coord_valid),
		.coord_ready  (coord_ready),
		.coord        (coord),
		.mapped_valid (mapped_valid),
		.mapped_ready (mapped_ready),
		.mapped       (mapped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint int_root(input longint n);
		longint res;
		longint probe;
		res   = 0;
		probe = 64'sd1 <<< 32;
		while (probe > n)
			probe = probe >>> 2;
		while (probe != 0) begin
			if (n >= res + probe) begin
				n   = n - (res + probe);
				res = (res >>> 1) + probe;
			end else begin
				res = res >>> 1;
			end
			probe = probe >>> 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] rescale(input longint c, input longint m,
			input longint r);
		longint mag_c;
		longint q;
		mag_c = (c < 0) ? -c : c;
		q = (2 * mag_c * m + r) / (2 * r);
		if (c < 0) begin
			if (q > 32768)
				q = 32768;
			return 16'(-q);
		end
		if (q > 32767)
			q = 32767;
		return 16'(q);
	endfunction

	function automatic fcm_pkg::mapped_beat_t fisheye_map(input fcm_pkg::coord_beat_t c,
			input logic [fcm_pkg::LENS_W-1:0] lens);
		longint u, v, r, big_r, x, y, z, dx, dy, m;
		fcm_pkg::mapped_beat_t res;
		u = c.u_coord;
		v = c.v_coord;
		r = int_root(u * u + v * v);
		big_r = (longint'(lens) * TWO_OVER_PI + (64'sd1 <<< 31)) >>> 32;
		res = '0;
		if (r == 0 || big_r == 0)
			return res;
		x = big_r <<< fcm_pkg::GUARD_W;
		y = r <<< fcm_pkg::GUARD_W;
		z = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_Q30[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_Q30[i];
			end
		end
		if (z < 0)
			z = 0;
		m = (big_r * z + (64'sd1 <<< 29)) >>> 30;
		if (m > 32768)
			m = 32768;
		res.mapped_u = rescale(u, m, r);
		res.mapped_v = rescale(v, m, r);
		return res;
	endfunction

	function automatic fcm_pkg::coord_beat_t random_coord(
			input logic [fcm_pkg::LENS_W-1:0] lens);
		fcm_pkg::coord_beat_t c;
		logic signed [15:0] picks [5] = '{-32768, 32767, 0, 1, -1};
		int span;
		c = fcm_pkg::coord_beat_t'($urandom);
		case ($urandom_range(8))
			5, 6: begin
				c.u_coord = 16'($signed($urandom_range(127)) - 64);
				c.v_coord = 16'($signed($urandom_range(127)) - 64);
			end
			7: begin
				c.u_coord = picks[$urandom_range(4)];
				c.v_coord = picks[$urandom_range(4)];
			end
			8: begin
				if ($urandom_range(1))
					c.u_coord = '0;
				else
					c.v_coord = '0;
			end
			default: begin
				span = (lens == 0) ? 1 : int'(lens);
				if ($urandom_range(3) == 0) begin
					c.u_coord = 16'($signed($urandom_range(2 * span)) - span);
					c.v_coord = 16'($signed($urandom_range(2 * span)) - span);
				end
			end
		endcase
		return c;
	endfunction

	task automatic apb_write(input logic [fcm_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == fcm_pkg::REG_LENS)
			lens_shadow = data[fcm_pkg::LENS_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check_lens();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {fcm_pkg::REG_LENS, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[fcm_pkg::LENS_W-1:0] !== lens_shadow) begin
			$display("%0t lens_radius readback expected %0d got %0d", $time,
				lens_shadow, prdata[fcm_pkg::LENS_W-1:0]);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_coord(input fcm_pkg::coord_beat_t c, input bit typed,
			input fcm_pkg::mapped_beat_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			coord_valid <= 1'b0;
		end
		@(negedge clk);
		coord_valid    <= 1'b1;
		coord          <= c;
		beat_typed     = typed;
		beat_typed_val = want;
		do @(posedge clk); while (!coord_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		coord_valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && coord_valid && coord_ready) begin
			if (beat_typed)
				pending_maps.push_back(beat_typed_val);
			else
				pending_maps.push_back(fisheye_map(coord, lens_shadow));
		end
	end

	always @(posedge clk) begin
		if (arst_n && mapped_valid && mapped_ready) begin
			if (pending_maps.size() == 0) begin
				$display("%0t unexpected mapped beat u=%0d v=%0d", $time,
					mapped.mapped_u, mapped.mapped_v);
				errors++;
			end else begin
				oldest_map = pending_maps.pop_front();
				if (mapped.mapped_u !== oldest_map.mapped_u) begin
					$display("%0t mapped_u expected %0d got %0d", $time,
						oldest_map.mapped_u, mapped.mapped_u);
					errors++;
				end
				if (mapped.mapped_v !== oldest_map.mapped_v) begin
					$display("%0t mapped_v expected %0d got %0d", $time,
						oldest_map.mapped_v, mapped.mapped_v);
					errors++;
				end
			end
		end
	end

	// output side: random backpressure, one long hold-off on request
	initial begin
		mapped_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				mapped_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (calm) begin
				mapped_ready <= 1'b1;
			end else begin
				mapped_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fisheye_coordinate_mapper verification failed");
		$finish;
	end

	initial begin
		logic [31:0] cur_word;
		logic [31:0] phase_words [NUM_PHASES];
		fcm_pkg::mapped_beat_t typed_val;
		fcm_pkg::coord_beat_t c;

		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		coord_valid    = 1'b0;
		coord          = '0;
		arst_n         = 1'b0;
		calm           = 1'b0;
		hold_req       = 1'b0;
		beat_typed     = 1'b0;
		beat_typed_val = '0;
		errors         = 0;
		lens_shadow    = fcm_pkg::LENS_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_check_lens();
		cur_word = {17'b0, fcm_pkg::LENS_RESET};
		foreach (directed[k]) begin
			if (directed[k].lens_word != cur_word) begin
				drain();
				cur_word = directed[k].lens_word;
				apb_write(fcm_pkg::REG_LENS, cur_word);
			end
			c.u_coord          = directed[k].u;
			c.v_coord          = directed[k].v;
			typed_val.mapped_u = directed[k].eu;
			typed_val.mapped_v = directed[k].ev;
			send_coord(c, directed[k].typed, typed_val);
		end

		// unused register index must leave the lens alone
		drain();
		apb_write(REG_UNUSED, 32'h0000_1234);
		apb_check_lens();

		phase_words = '{$urandom, 32'h0000_7FFF, 32'h0000_0001, 32'h0000_4000,
			32'($urandom_range(100, 2)), 32'h0000_0000};
		typed_val = '0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			apb_write(fcm_pkg::REG_LENS, phase_words[p]);
			apb_check_lens();
			calm = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 40)
					hold_req = 1'b1;
				if (p == 2 && n == 100)
					drain();
				send_coord(random_coord(lens_shadow), 1'b0, typed_val);
			end
		end
		calm = 1'b0;

		drain();
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("fisheye_coordinate_mapper verification clean");
		else
			$display("fisheye_coordinate_mapper verification failed");
		$finish;
	end

endmodule
